/* hdl/u8cpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8cpd_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned AFT_W  = 2;

  // byte class masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // payload masks for lead and continuation bytes
  localparam logic [7:0] LEAD2_VAL = 8'h1F;
  localparam logic [7:0] LEAD3_VAL = 8'h0F;
  localparam logic [7:0] LEAD4_VAL = 8'h07;
  localparam logic [7:0] CONT_VAL  = 8'h3F;

  // replacement character '?'
  localparam logic [CP_W-1:0] REPL_CP = 21'd63;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last_of_run;
  } result_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0]      pend;
    logic [CP_W-1:0] partial;
    logic            discard;
  } dec_state_t;

  // everything the decoder produces for one byte
  typedef struct packed {
    dec_state_t nxt;
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

endpackage

/* hdl/utf8_codepoint_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_core
// Streaming UTF-8 decoder: one text byte in, zero to two code points out.
//
//  channel | dir | tdata                               | tuser          | tlast
//  in_     | in  | [7:0] data_byte, [9:8] bytes_after  | -              | -
//  out_    | out | [20:0] code_point                   | is_replacement | last_of_run
//
// One byte is accepted per cycle while the result queue has room. A byte is
// decoded in the cycle after its transfer, and its results are offered on out_
// from the result queue once it leaves the input register. Output bandwidth
// sets the pace: a byte leaves the input register when its results fit in the
// two-slot queue after this cycle's out_ transfer, so a byte with two results
// can hold back the next byte. Reset clears the decoder state and empties the
// queue. A stall on out_ fills the queue and then holds the input register.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_core
  import u8cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [9:8] bytes_after
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point
  output logic        out_tuser,  // [0] is_replacement
  output logic        out_tlast
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [AFT_W-1:0]  s1_after_r;
  dec_state_t        state_r;
  dec_out_t          dec;
  logic              s1_fire;
  logic [1:0]        push_cnt;
  logic [1:0]        level;
  logic [2:0]        need;
  result_t           head;
  logic              head_valid;
  logic              in_xfer;
  logic              out_xfer;

  // input register
  assign in_xfer = in_tvalid && in_tready;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_tdata[BYTE_W-1:0];
      s1_after_r <= in_tdata[BYTE_W+AFT_W-1:BYTE_W];
    end
  end

  // decode step
  u8cpd_decode u_decode (
    .cur         (state_r),
    .data_byte   (s1_byte_r),
    .bytes_after (s1_after_r),
    .dout        (dec)
  );

  // the byte leaves the input register once its results fit in the queue,
  // counting the slot freed by this cycle's output transfer
  assign need      = {1'b0, level} + {1'b0, dec.n_res};
  assign s1_fire   = s1_valid_r && (need <= 3'd2 + {2'b00, out_xfer});
  assign in_tready = !s1_valid_r || s1_fire;
  assign push_cnt  = s1_fire ? dec.n_res : 2'd0;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= dec.nxt;
    end
  end

  // result queue
  assign out_xfer = out_tvalid && out_tready;

  u8cpd_rfifo u_rfifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (dec.res0),
    .push1      (dec.res1),
    .pop        (out_xfer),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {3'b000, head.code_point};
  assign out_tuser  = head.is_replacement;
  assign out_tlast  = head.last_of_run;

  // checks
  a_level_max : assert property (@(posedge clk) disable iff (!rst_n)
    level != 2'd3)
    else $error("result queue overfilled");

  a_pair_room : assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd2 |-> level == 2'd0 || (level == 2'd1 && out_xfer))
    else $error("result pair pushed without two free slots");

  a_pair_shape : assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd2 |-> dec.res0.is_replacement && !dec.res0.last_of_run &&
                         dec.res1.last_of_run)
    else $error("result pair not led by a replacement");

  a_discard_idle : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.discard |-> state_r.pend == 2'd0)
    else $error("discard set with continuations pending");

endmodule

/* hdl/u8cpd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_decode
// Single-byte UTF-8 decode step: results and next state from current state.
// ----------------------------------------------------------------------------
module u8cpd_decode
  import u8cpd_pkg::*;
(
  input  dec_state_t        cur,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [AFT_W-1:0]  bytes_after,
  output dec_out_t          dout
);

  logic            is_cont;
  logic [1:0]      extra;
  logic [CP_W-1:0] lead_val;
  logic            lead_has_res;
  result_t         lead_res;
  logic [CP_W-1:0] shifted;

  // lead byte classification
  always_comb begin
    is_cont  = (data_byte & CONT_MASK) == CONT_PAT;
    extra    = 2'd0;
    lead_val = '0;
    if ((data_byte & LEAD2_MASK) == LEAD2_PAT) begin
      extra    = 2'd1;
      lead_val = CP_W'(data_byte & LEAD2_VAL);
    end else if ((data_byte & LEAD3_MASK) == LEAD3_PAT) begin
      extra    = 2'd2;
      lead_val = CP_W'(data_byte & LEAD3_VAL);
    end else if ((data_byte & LEAD4_MASK) == LEAD4_PAT) begin
      extra    = 2'd3;
      lead_val = CP_W'(data_byte & LEAD4_VAL);
    end
    shifted = {cur.partial[CP_W-7:0], data_byte[5:0]};
  end

  // outcome of treating the byte as a lead
  always_comb begin
    lead_has_res = 1'b1;
    lead_res     = '{code_point: REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};
    if (!data_byte[7]) begin
      lead_res = '{code_point: CP_W'(data_byte), is_replacement: 1'b0, last_of_run: 1'b0};
    end else if (extra == 2'd0 || extra > bytes_after) begin
      lead_res = '{code_point: REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};
    end else begin
      lead_has_res = 1'b0;
    end
  end

  // state update and result selection
  always_comb begin
    dout       = '0;
    dout.nxt   = cur;
    if (cur.discard) begin
      // drop bytes until the text end
      if (bytes_after == '0) begin
        dout.nxt.discard = 1'b0;
      end
    end else if (cur.pend != 2'd0 && is_cont) begin
      // continuation gathered into the partial value
      dout.nxt.partial = shifted;
      dout.nxt.pend    = cur.pend - 2'd1;
      if (cur.pend == 2'd1) begin
        dout.n_res = 2'd1;
        dout.res0  = '{code_point: shifted, is_replacement: 1'b0, last_of_run: 1'b0};
      end
    end else begin
      // missing continuation gives a replacement before the lead result
      if (cur.pend != 2'd0) begin
        dout.nxt.pend    = 2'd0;
        dout.nxt.partial = '0;
        dout.n_res       = 2'd1;
        dout.res0        = '{code_point: REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};
      end
      if (lead_has_res) begin
        if (cur.pend != 2'd0) begin
          dout.n_res = 2'd2;
          dout.res1  = lead_res;
        end else begin
          dout.n_res = 2'd1;
          dout.res0  = lead_res;
        end
        if (data_byte[7] && extra != 2'd0 && bytes_after != '0) begin
          dout.nxt.discard = 1'b1;
        end
      end else begin
        dout.nxt.pend    = extra;
        dout.nxt.partial = lead_val;
      end
    end
    // mark the final result of this byte
    if (dout.n_res == 2'd1) begin
      dout.res0.last_of_run = 1'b1;
    end else if (dout.n_res == 2'd2) begin
      dout.res1.last_of_run = 1'b1;
    end
  end

endmodule

/* hdl/u8cpd_rfifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_rfifo
// Two-slot result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module u8cpd_rfifo
  import u8cpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output result_t    head,
  output logic       head_valid,
  output logic [1:0] level
);

  result_t    slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] level_r;
  logic [1:0] level_nxt;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_cnt[0];
    rd_ptr_nxt = rd_ptr_r ^ pop;
    level_nxt  = level_r + push_cnt - {1'b0, pop};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // result slots; a pair is only pushed when both slots are free after this
  // cycle's pop, so the second slot may be the one being read out
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slot_r[~wr_ptr_r] <= push1;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = level_r != 2'd0;
  assign level      = level_r;

endmodule

/* verif/tb_utf8_codepoint_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder_core
// Self-checking bench for the streaming UTF-8 code point decoder. A short
// directed run covers the byte classes and the malformed-text cases, then
// random texts are fed: mostly well-formed with random content, some broken
// by dropped or stray bytes and some with a wrong remaining-byte count. A
// scoreboard predicts the code points for every accepted transfer and checks
// each result transfer in order. Both sides stall at random in bursts.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder_core;
  import u8cpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned QUIET_FROM   = 520;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef logic [7:0] text_q_t[$];

  // expected code points and the decoder state that produces them
  class codepoint_scoreboard;
    result_t             expected_cps[$];
    logic [1:0]          pend_cont;
    logic [CP_W-1:0]     partial_cp;
    logic                dropping_text;
    int unsigned         mismatches;

    function new();
      expected_cps.delete();
      pend_cont     = '0;
      partial_cp    = '0;
      dropping_text = 1'b0;
      mismatches    = 0;
    endfunction

    // returns 1 when the byte was decoded, 0 when it was dropped
    function bit note_byte(logic [7:0] b, logic [1:0] after);
      result_t         got[2];
      int              n;
      logic [1:0]      need;
      logic [CP_W-1:0] lead_bits;
      n = 0;
      need = '0;
      lead_bits = '0;
      // rest of a text that ran short is thrown away
      if (dropping_text) begin
        if (after == 2'd0) dropping_text = 1'b0;
        return 1'b0;
      end
      // continuation expected
      if (pend_cont != 2'd0) begin
        if ((b & CONT_MASK) == CONT_PAT) begin
          partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
          pend_cont  = pend_cont - 2'd1;
          if (pend_cont == 2'd0) begin
            got[0] = '{code_point: partial_cp, is_replacement: 1'b0, last_of_run: 1'b1};
            expected_cps.insert(expected_cps.size(), got[0]);
          end
          return 1'b1;
        end
        got[n] = '{code_point: REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};
        n++;
        pend_cont  = '0;
        partial_cp = '0;
      end
      // lead byte
      if (b[7] == 1'b0) begin
        got[n] = '{code_point: CP_W'(b), is_replacement: 1'b0, last_of_run: 1'b0};
        n++;
      end else begin
        if ((b & LEAD2_MASK) == LEAD2_PAT) begin
          need = 2'd1;
          lead_bits = CP_W'(b & LEAD2_VAL);
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
          need = 2'd2;
          lead_bits = CP_W'(b & LEAD3_VAL);
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
          need = 2'd3;
          lead_bits = CP_W'(b & LEAD4_VAL);
        end
        if (need == 2'd0 || need > after) begin
          got[n] = '{code_point: REPL_CP, is_replacement: 1'b1, last_of_run: 1'b0};
          n++;
          if (need != 2'd0 && after != 2'd0) dropping_text = 1'b1;
        end else begin
          pend_cont  = need;
          partial_cp = lead_bits;
        end
      end
      if (n > 0) got[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_cps.insert(expected_cps.size(), got[i]);
      return 1'b1;
    endfunction

    function void check_result(logic [CP_W-1:0] cp, logic repl, logic last);
      result_t want;
      if (expected_cps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cp=%0h repl=%0b last=%0b", cp, repl, last);
        return;
      end
      want = expected_cps.pop_front();
      if (want.code_point !== cp || want.is_replacement !== repl ||
          want.last_of_run !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: cp exp %0h got %0h, repl exp %0b got %0b, last exp %0b got %0b",
                   want.code_point, cp, want.is_replacement, repl, want.last_of_run, last);
      end
    endfunction

    function int outstanding();
      return expected_cps.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  codepoint_scoreboard sb;
  int unsigned         cycles;
  int unsigned         decoded_bytes;
  bit                  quiet;
  bit                  tx_bursty;
  text_q_t             text_buf;

  utf8_codepoint_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall bursts with calm stretches in between
  int unsigned stall_left;
  int unsigned phase_left;
  bit          rx_calm;
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    phase_left = 0;
    rx_calm    = 1'b0;
  end
  always @(posedge clk) begin
    if (phase_left == 0) begin
      phase_left <= $urandom_range(50, 300);
      rx_calm    <= ($urandom_range(0, 2) == 0);
    end else begin
      phase_left <= phase_left - 1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && !rx_calm && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor: sample before the edge, check at the edge
  logic            res_seen;
  logic [CP_W-1:0] res_cp;
  logic            res_repl;
  logic            res_last;
  initial res_seen = 1'b0;
  always @(negedge clk) begin
    res_seen <= rst_n && out_tvalid && out_tready;
    res_cp   <= out_tdata[CP_W-1:0];
    res_repl <= out_tuser;
    res_last <= out_tlast;
  end
  always @(posedge clk) begin
    if (res_seen) sb.check_result(res_cp, res_repl, res_last);
  end

  // one byte transfer; valid stays high afterwards
  task automatic send_byte(logic [7:0] b, logic [1:0] after);
    bit taken;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, after, b};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    if (sb.note_byte(b, after)) decoded_bytes++;
  endtask

  task automatic maybe_gap();
    if (tx_bursty && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // feed a text with the true remaining count, optionally lying now and then
  task automatic send_text(text_q_t t, bit may_lie);
    int         rest;
    logic [1:0] after;
    for (int i = 0; i < t.size(); i++) begin
      rest  = t.size() - 1 - i;
      after = (rest > 3) ? 2'd3 : 2'(rest);
      if (may_lie && $urandom_range(0, 19) == 0) after = 2'($urandom_range(0, 3));
      maybe_gap();
      send_byte(t[i], after);
    end
  endtask

  task automatic wait_all_decoded();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // random text: mostly well-formed, sometimes noise or a broken sequence
  task automatic make_random_text();
    int         nch;
    int         kind;
    int         cut;
    logic [7:0] b;
    text_buf.delete();
    nch = $urandom_range(1, 8);
    for (int c = 0; c < nch; c++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        b = 8'($urandom_range(0, 127));
        text_buf.insert(text_buf.size(), b);
      end else if (kind <= 5) begin
        text_buf.insert(text_buf.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        text_buf.insert(text_buf.size(), cont_byte());
      end else if (kind <= 7) begin
        text_buf.insert(text_buf.size(), 8'hE0 | 8'($urandom_range(0, 15)));
        repeat (2) text_buf.insert(text_buf.size(), cont_byte());
      end else if (kind == 8) begin
        text_buf.insert(text_buf.size(), 8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) text_buf.insert(text_buf.size(), cont_byte());
      end else begin
        text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(0, text_buf.size() - 1);
      if ($urandom_range(0, 1) == 0) text_buf.delete(cut);
      else text_buf.insert(cut, 8'($urandom_range(0, 255)));
    end
    if (text_buf.size() == 0) text_buf.insert(0, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    quiet         = 1'b0;
    tx_bursty     = 1'b1;
    decoded_bytes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ascii extremes and well-formed sequences of each length
    send_text('{8'h00}, 1'b0);
    send_text('{8'h7F}, 1'b0);
    send_text('{8'hC2, 8'hA9}, 1'b0);
    send_text('{8'hE2, 8'h82, 8'hAC}, 1'b0);
    send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
    // invalid leads: stray continuation and 11111xxx
    send_text('{8'h80}, 1'b0);
    send_text('{8'hFF}, 1'b0);
    send_text('{8'hF8}, 1'b0);
    // sequence longer than the text: mid-text drops the rest, at the end not
    send_text('{8'hE2, 8'h82}, 1'b0);
    send_text('{8'hC3}, 1'b0);
    // missing continuation, byte re-read as ascii then as a new lead
    send_text('{8'hC3, 8'h41}, 1'b0);
    send_text('{8'hE2, 8'hC3, 8'hA9}, 1'b0);
    // pending sequence at a claimed text end just carries on
    send_byte(8'hE2, 2'd2);
    send_byte(8'h82, 2'd0);
    send_byte(8'hAC, 2'd0);
    wait_all_decoded();

    // random texts
    decoded_bytes = 0;
    while (decoded_bytes < RANDOM_BYTES) begin
      quiet     = (decoded_bytes >= QUIET_FROM);
      tx_bursty = ($urandom_range(0, 2) != 0);
      make_random_text();
      send_text(text_buf, 1'b1);
      if (decoded_bytes >= RANDOM_BYTES / 2 && decoded_bytes < RANDOM_BYTES / 2 + 10)
        wait_all_decoded();
    end

    wait_all_decoded();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/u8cpd_pkg.sv
hdl/u8cpd_decode.sv
hdl/u8cpd_rfifo.sv
hdl/utf8_codepoint_decoder_core.sv
verif/tb_utf8_codepoint_decoder_core.sv
